### rtl/nsd_pkg.sv
// ---------------------------------------------------------------------------
// nsd_pkg
// Shared types, character codes and helpers of the sentence deframer.
// ---------------------------------------------------------------------------
package nsd_pkg;

  localparam int BYTE_W = 8;
  localparam int EV_W   = 3;
  localparam int CNT_W  = 32;

  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd200;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_DATA = 6'b000010,
    PH_SUM1 = 6'b000100,
    PH_SUM2 = 6'b001000,
    PH_CR   = 6'b010000,
    PH_LF   = 6'b100000
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_GOOD     = 3'd2,
    EV_SUMBAD   = 3'd3,
    EV_FRAMEBAD = 3'd4,
    EV_OVERFLOW = 3'd5,
    EV_STRAY    = 3'd6
  } event_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] line_length;
    logic [BYTE_W-1:0] checksum_received;
    logic [BYTE_W-1:0] checksum_computed;
    logic [CNT_W-1:0]  good_line_count;
    logic [CNT_W-1:0]  error_count;
    logic [CNT_W-1:0]  stray_count;
  } result_t;

  // Bit 4 is set when the character is no hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = {1'b0, 4'(c - 8'h57)};
    end
    return d;
  endfunction

  function automatic logic [BYTE_W-1:0] decode_pair(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
    logic [4:0] a;
    logic [4:0] b;
    logic [BYTE_W-1:0] v;
    a = hex_digit(hi);
    b = hex_digit(lo);
    if (a[4]) begin
      v = '0;
    end else if (b[4]) begin
      v = {4'h0, a[3:0]};
    end else begin
      v = {a[3:0], b[3:0]};
    end
    return v;
  endfunction

endpackage

### rtl/nsd_in_if.sv
// ---------------------------------------------------------------------------
// nsd_in_if
// Received byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface nsd_in_if
  import nsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/nsd_out_if.sv
// ---------------------------------------------------------------------------
// nsd_out_if
// Deframer result channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface nsd_out_if
  import nsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] payload_index;
  logic [BYTE_W-1:0] line_length;
  logic [BYTE_W-1:0] checksum_received;
  logic [BYTE_W-1:0] checksum_computed;
  logic [CNT_W-1:0]  good_line_count;
  logic [CNT_W-1:0]  error_count;
  logic [CNT_W-1:0]  stray_count;

  modport source (
    output valid, output event_res, output payload_byte, output payload_index,
    output line_length, output checksum_received, output checksum_computed,
    output good_line_count, output error_count, output stray_count,
    input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input payload_index,
    input line_length, input checksum_received, input checksum_computed,
    input good_line_count, input error_count, input stray_count,
    output ready
  );
endinterface

### rtl/nmea_sentence_deframer.sv
// ---------------------------------------------------------------------------
// nmea_sentence_deframer
// Sentence framing and XOR checksum check on a received byte stream.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle while the result side keeps up and
// returns exactly one result per byte. A byte is held in an input register,
// decoded in one pass by the framing state machine and written to the
// result register, which offers it on the result channel. The max_payload
// register is to be written through cfg_we and cfg_wdata only while no byte
// is in flight; the block itself does not enforce this.
module nmea_sentence_deframer
  import nsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nsd_in_if.sink            in_bus,
  nsd_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_free;
  logic              advance;
  logic              in_fire;
  result_t           res;

  assign advance      = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_bus.rx_byte;
    end
  end

  nsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (s1_byte_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  nsd_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .res     (res),
    .free    (out_free),
    .out_bus (out_bus)
  );

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |-> !advance)
    else $error("result overwritten before transfer");

  // A good line always carries matching checksums.
  a_good_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (out_bus.event_res == EV_GOOD)
      |-> out_bus.checksum_received == out_bus.checksum_computed)
    else $error("good line with checksum mismatch");

endmodule

### rtl/nsd_core.sv
// ---------------------------------------------------------------------------
// nsd_core
// Framing state machine, checksum, counters and the max_payload register.
// ---------------------------------------------------------------------------
module nsd_core
  import nsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] max_payload_r;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] cksum_r, cksum_nxt;
  logic [CNT_W-1:0]  lines_r, lines_nxt;
  logic [CNT_W-1:0]  errors_r, errors_nxt;
  logic [CNT_W-1:0]  strays_r, strays_nxt;
  event_t            ev;
  logic [BYTE_W-1:0] pbyte;
  logic [BYTE_W-1:0] pidx;
  logic [BYTE_W-1:0] llen;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    first_nxt  = first_r;
    cksum_nxt  = cksum_r;
    lines_nxt  = lines_r;
    errors_nxt = errors_r;
    strays_nxt = strays_r;
    ev         = EV_NONE;
    pbyte      = '0;
    pidx       = '0;
    llen       = '0;
    case (phase_r)
      PH_DATA: begin
        if (rx_byte == CH_STAR) begin
          phase_nxt = PH_SUM1;
        end else if (count_r >= max_payload_r) begin
          errors_nxt = errors_r + 1'b1;
          ev         = EV_OVERFLOW;
          phase_nxt  = PH_HUNT;
        end else begin
          ev        = EV_PAYLOAD;
          pbyte     = rx_byte;
          pidx      = count_r;
          xor_nxt   = xor_r ^ rx_byte;
          count_nxt = count_r + 1'b1;
        end
      end
      PH_SUM1: begin
        first_nxt = rx_byte;
        phase_nxt = PH_SUM2;
      end
      PH_SUM2: begin
        cksum_nxt = decode_pair(first_r, rx_byte);
        if (cksum_nxt == xor_r) begin
          phase_nxt = PH_CR;
        end else begin
          errors_nxt = errors_r + 1'b1;
          ev         = EV_SUMBAD;
          phase_nxt  = PH_HUNT;
        end
      end
      PH_CR: begin
        if (rx_byte == CH_CR) begin
          phase_nxt = PH_LF;
        end else begin
          errors_nxt = errors_r + 1'b1;
          ev         = EV_FRAMEBAD;
          phase_nxt  = PH_HUNT;
        end
      end
      PH_LF: begin
        if (rx_byte == CH_LF) begin
          lines_nxt = lines_r + 1'b1;
          ev        = EV_GOOD;
          llen      = count_r;
        end else begin
          errors_nxt = errors_r + 1'b1;
          ev         = EV_FRAMEBAD;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        if (rx_byte == CH_START) begin
          count_nxt = '0;
          xor_nxt   = '0;
          phase_nxt = PH_DATA;
        end else begin
          strays_nxt = strays_r + 1'b1;
          ev         = EV_STRAY;
          phase_nxt  = PH_HUNT;
        end
      end
    endcase

    res.event_res         = ev;
    res.payload_byte      = pbyte;
    res.payload_index     = pidx;
    res.line_length       = llen;
    res.checksum_received = cksum_nxt;
    res.checksum_computed = xor_nxt;
    res.good_line_count   = lines_nxt;
    res.error_count       = errors_nxt;
    res.stray_count       = strays_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      max_payload_r <= MAX_PAYLOAD_RESET;
      count_r       <= '0;
      xor_r         <= '0;
      first_r       <= '0;
      cksum_r       <= '0;
      lines_r       <= '0;
      errors_r      <= '0;
      strays_r      <= '0;
    end else begin
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
      if (advance) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        xor_r    <= xor_nxt;
        first_r  <= first_nxt;
        cksum_r  <= cksum_nxt;
        lines_r  <= lines_nxt;
        errors_r <= errors_nxt;
        strays_r <= strays_nxt;
      end
    end
  end

  // Each byte adds at most one error.
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (errors_r == $past(errors_r)) || (errors_r == $past(errors_r) + 32'd1))
    else $error("error counter moved by more than one");

  // The line state only changes when a byte is consumed.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(count_r) && $stable(xor_r))
    else $error("line state changed without a byte");

endmodule

### rtl/nsd_out_stage.sv
// ---------------------------------------------------------------------------
// nsd_out_stage
// Result register that drives the output channel.
// ---------------------------------------------------------------------------
module nsd_out_stage
  import nsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    free,
  nsd_out_if.source out_bus
);

  logic    valid_r;
  result_t data_r;

  assign free = !valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_bus.valid             = valid_r;
  assign out_bus.event_res         = data_r.event_res;
  assign out_bus.payload_byte      = data_r.payload_byte;
  assign out_bus.payload_index     = data_r.payload_index;
  assign out_bus.line_length       = data_r.line_length;
  assign out_bus.checksum_received = data_r.checksum_received;
  assign out_bus.checksum_computed = data_r.checksum_computed;
  assign out_bus.good_line_count   = data_r.good_line_count;
  assign out_bus.error_count       = data_r.error_count;
  assign out_bus.stray_count       = data_r.stray_count;

endmodule

### sim/nsd_deframe_monitor.sv
// ---------------------------------------------------------------------------
// nsd_deframe_monitor
// Watches both channels of the sentence deframer, predicts each result and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module nsd_deframe_monitor
  import nsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  nsd_in_if                 in_mon,
  nsd_out_if                out_mon,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  output int unsigned       results_pending,
  output int unsigned       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t            frame_state;
  logic [BYTE_W-1:0] limit_bytes;
  logic [BYTE_W-1:0] byte_count;
  logic [BYTE_W-1:0] xor_acc;
  logic [BYTE_W-1:0] hex_hi;
  logic [BYTE_W-1:0] sum_held;
  logic [CNT_W-1:0]  good_lines;
  logic [CNT_W-1:0]  bad_lines;
  logic [CNT_W-1:0]  strays;

  result_t predicted_events[$];

  task automatic report_fault(input string msg);
    $display("%0t ns deframer mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic field_check(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return 5'h10;
  endfunction

  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] c);
    result_t    r;
    logic [4:0] hi_n;
    logic [4:0] lo_n;
    r = '0;
    r.event_res = EV_NONE;
    case (frame_state)
      PH_DATA: begin
        if (c == CH_STAR) begin
          frame_state = PH_SUM1;
        end else if (byte_count >= limit_bytes) begin
          bad_lines++;
          r.event_res = EV_OVERFLOW;
          frame_state = PH_HUNT;
        end else begin
          r.event_res = EV_PAYLOAD;
          r.payload_byte = c;
          r.payload_index = byte_count;
          xor_acc = xor_acc ^ c;
          byte_count++;
        end
      end
      PH_SUM1: begin
        hex_hi = c;
        frame_state = PH_SUM2;
      end
      PH_SUM2: begin
        hi_n = hex_nibble(hex_hi);
        lo_n = hex_nibble(c);
        if (hi_n[4]) begin
          sum_held = '0;
        end else if (lo_n[4]) begin
          sum_held = {4'h0, hi_n[3:0]};
        end else begin
          sum_held = {hi_n[3:0], lo_n[3:0]};
        end
        if (sum_held == xor_acc) begin
          frame_state = PH_CR;
        end else begin
          bad_lines++;
          r.event_res = EV_SUMBAD;
          frame_state = PH_HUNT;
        end
      end
      PH_CR: begin
        if (c == CH_CR) begin
          frame_state = PH_LF;
        end else begin
          bad_lines++;
          r.event_res = EV_FRAMEBAD;
          frame_state = PH_HUNT;
        end
      end
      PH_LF: begin
        if (c == CH_LF) begin
          good_lines++;
          r.event_res = EV_GOOD;
          r.line_length = byte_count;
        end else begin
          bad_lines++;
          r.event_res = EV_FRAMEBAD;
        end
        frame_state = PH_HUNT;
      end
      default: begin
        if (c == CH_START) begin
          byte_count = '0;
          xor_acc = '0;
          frame_state = PH_DATA;
        end else begin
          strays++;
          r.event_res = EV_STRAY;
          frame_state = PH_HUNT;
        end
      end
    endcase
    r.checksum_received = sum_held;
    r.checksum_computed = xor_acc;
    r.good_line_count = good_lines;
    r.error_count = bad_lines;
    r.stray_count = strays;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      frame_state = PH_HUNT;
      limit_bytes = MAX_PAYLOAD_RESET;
      byte_count = '0;
      xor_acc = '0;
      hex_hi = '0;
      sum_held = '0;
      good_lines = '0;
      bad_lines = '0;
      strays = '0;
      fail_count = 0;
      predicted_events.delete();
    end else begin
      if (cfg_we) begin
        limit_bytes = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.event_res = out_mon.event_res;
        got.payload_byte = out_mon.payload_byte;
        got.payload_index = out_mon.payload_index;
        got.line_length = out_mon.line_length;
        got.checksum_received = out_mon.checksum_received;
        got.checksum_computed = out_mon.checksum_computed;
        got.good_line_count = out_mon.good_line_count;
        got.error_count = out_mon.error_count;
        got.stray_count = out_mon.stray_count;
        if (predicted_events.size() == 0) begin
          report_fault($sformatf("result transfer with event %0d and nothing expected",
                                 got.event_res));
        end else begin
          want = predicted_events.pop_front();
          field_check("event_res", CNT_W'(got.event_res), CNT_W'(want.event_res));
          field_check("payload_byte", CNT_W'(got.payload_byte),
                      CNT_W'(want.payload_byte));
          field_check("payload_index", CNT_W'(got.payload_index),
                      CNT_W'(want.payload_index));
          field_check("line_length", CNT_W'(got.line_length), CNT_W'(want.line_length));
          field_check("checksum_received", CNT_W'(got.checksum_received),
                      CNT_W'(want.checksum_received));
          field_check("checksum_computed", CNT_W'(got.checksum_computed),
                      CNT_W'(want.checksum_computed));
          field_check("good_line_count", got.good_line_count, want.good_line_count);
          field_check("error_count", got.error_count, want.error_count);
          field_check("stray_count", got.stray_count, want.stray_count);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_events.push_back(deframe_byte(in_mon.rx_byte));
      end
    end
    results_pending <= predicted_events.size();
  end

endmodule

### sim/nmea_sentence_deframer_tb.sv
// ---------------------------------------------------------------------------
// nmea_sentence_deframer_tb
// Stimulus and verdict for the sentence deframer.
// ---------------------------------------------------------------------------
// Sends a short set of hand-made lines covering every event, then random
// sentences (mostly well formed, some broken, some noise) under several
// max_payload settings, with random idling on both channels, long result
// stalls and full drains between settings. The monitor does the checking.
module nmea_sentence_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsd_pkg::*;

  typedef enum {LN_GOOD, LN_SUMBAD, LN_ENDBAD, LN_OVERFLOW, LN_NOISE} line_kind_t;

  localparam logic [BYTE_W-1:0] NON_HEX [8] =
    '{8'h47, 8'h67, 8'h7A, 8'h20, 8'h0D, 8'h00, 8'hFF, 8'h2A};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;
  int unsigned       results_pending;
  int unsigned       fail_count;

  bit                src_idles;
  bit                sink_idles;
  int unsigned       hold_requests;
  int unsigned       bytes_sent;
  int unsigned       lines_made;
  int unsigned       settings_made;
  logic [BYTE_W-1:0] line_q[$];

  nsd_in_if  in_bus();
  nsd_out_if out_bus();

  nmea_sentence_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  nsd_deframe_monitor deframe_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .results_pending(results_pending),
    .fail_count     (fail_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (holds_served != hold_requests) begin
        hold_left = 120;
        holds_served = hold_requests;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= !(sink_idles && $urandom_range(99) < 38);
      end
      @(posedge clk);
    end
  end

  function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (src_idles && $urandom_range(99) < 38) begin
      in_bus.valid <= 1'b0;
      in_bus.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [BYTE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_made++;
  endtask

  task automatic make_line(input line_kind_t kind, input int unsigned len);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] sent;
    line_q.delete();
    if (kind == LN_NOISE) begin
      repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    line_q.push_back(CH_START);
    x = '0;
    repeat (len) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_STAR) c = 8'h2B;
      line_q.push_back(c);
      x = x ^ c;
    end
    if (kind == LN_OVERFLOW) return;
    line_q.push_back(CH_STAR);
    sent = (kind == LN_SUMBAD) ? (x ^ 8'($urandom_range(1, 255))) : x;
    if (sent == 8'h00 && $urandom_range(3) == 0) begin
      line_q.push_back(NON_HEX[3'($urandom_range(7))]);
      line_q.push_back(8'($urandom_range(0, 255)));
    end else if (sent < 8'h10 && $urandom_range(1) == 0) begin
      line_q.push_back(hex_ascii(sent[3:0], 1'($urandom_range(1))));
      line_q.push_back(NON_HEX[3'($urandom_range(7))]);
    end else begin
      line_q.push_back(hex_ascii(sent[7:4], 1'($urandom_range(1))));
      line_q.push_back(hex_ascii(sent[3:0], 1'($urandom_range(1))));
    end
    if (kind == LN_ENDBAD) begin
      c = ($urandom_range(2) == 0) ? CH_START : 8'($urandom_range(0, 255));
      if ($urandom_range(1) == 0) begin
        if (c == CH_CR) c = CH_START;
        line_q.push_back(c);
      end else begin
        if (c == CH_LF) c = CH_START;
        line_q.push_back(CH_CR);
        line_q.push_back(c);
      end
    end else begin
      line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    lines_made++;
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] limit, input int unsigned n_bytes,
                           input bit with_idle, input bit with_hold);
    int unsigned start_count;
    int unsigned cap;
    int unsigned len;
    int unsigned r;
    bit          hold_done;
    line_kind_t  kind;
    drain();
    write_limit(limit);
    src_idles = with_idle;
    sink_idles = with_idle;
    hold_done = 1'b0;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      if (with_hold && !hold_done && bytes_sent - start_count >= 20) begin
        hold_requests++;
        hold_done = 1'b1;
      end
      r = $urandom_range(99);
      kind = (r < 62) ? LN_GOOD : (r < 72) ? LN_SUMBAD : (r < 80) ? LN_ENDBAD :
             (r < 87) ? LN_OVERFLOW : LN_NOISE;
      cap = (limit < 12) ? limit : 12;
      len = $urandom_range(0, cap);
      if (kind == LN_OVERFLOW) begin
        if (limit <= 16) len = limit + 1;
        else kind = LN_GOOD;
      end
      make_line(kind, len);
      send_line();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.rx_byte = '0;
    src_idles = 1'b1;
    sink_idles = 1'b1;
    hold_requests = 0;
    bytes_sent = 0;
    lines_made = 0;
    settings_made = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-made lines: good line with a lowercase hex checksum, overflow,
    // hex digit followed by a non-hex character, non-hex first character,
    // bad line end where the start character is swallowed, stray and bad CR.
    write_limit(8'd2);
    send_text("$J*4a\r\n");
    send_text("$xyz");
    send_text("$*Fg");
    send_text("$*Z\r$");
    send_byte(8'h00);
    send_text("$*00");
    send_byte(8'hFF);
    lines_made += 6;

    run_phase(8'd1, 60, 1'b1, 1'b0);

    drain();
    write_limit(8'd255);
    src_idles = 1'b0;
    sink_idles = 1'b0;
    make_line(LN_GOOD, 255);
    send_line();
    run_phase(8'd255, 40, 1'b0, 1'b0);

    run_phase(8'd7, 80, 1'b1, 1'b1);
    run_phase(8'd16, 50, 1'b1, 1'b0);
    run_phase(8'd200, 50, 1'b1, 1'b1);
    run_phase(8'd3, 60, 1'b1, 1'b0);

    drain();
    repeat (6) @(posedge clk);
    $display("Summary: %0d bytes in %0d lines over %0d max_payload settings,",
             bytes_sent, lines_made, settings_made);
    $display("  with random idling, long result stalls and full drains between settings.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/nsd_pkg.sv
rtl/nsd_in_if.sv
rtl/nsd_out_if.sv
rtl/nsd_core.sv
rtl/nsd_out_stage.sv
rtl/nmea_sentence_deframer.sv
sim/nsd_deframe_monitor.sv
sim/nmea_sentence_deframer_tb.sv
